FILE: rtl/core/clbp_pkg.sv
// ----------------------------------------------------------------------------
// clbp_pkg: shared types and constants for the circular LBP block
// Holds the request payload types, the work entry that passes from the front
// part to the back part, the register index codes and the fixed constants.
// ----------------------------------------------------------------------------
package clbp_pkg;

  // Widths fixed by the request formats.
  localparam int PIXEL_W     = 8;
  localparam int OUT_COL_W   = 10;
  localparam int IMG_COLS_W  = 11;
  localparam int IMG_ROWS_W  = 12;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 1;

  // Column address carried in a work entry; wide enough for the largest
  // supported line length.
  localparam int COL_W = 12;

  // Geometry limits and reset values.
  localparam int MIN_GEOM  = 3;
  localparam int MAX_ROWS  = 4095;
  localparam logic [IMG_COLS_W-1:0] IMG_COLS_RESET = 11'd25;
  localparam logic [IMG_ROWS_W-1:0] IMG_ROWS_RESET = 12'd30;

  // Exact diagonal weights in Q0.32; rounded to the working precision at
  // elaboration.
  localparam logic [63:0] EDGE_Q32 = 64'd889516851;
  localparam logic [63:0] MID_Q32  = 64'd368449946;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_COLUMNS,
    REG_IMAGE_ROWS
  } cfg_reg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0]   lbp_code;
    logic [OUT_COL_W-1:0] out_column;
    logic                 last_of_frame;
  } out_item_t;

  // One accepted pixel after classification by the front part.
  typedef struct packed {
    logic [PIXEL_W-1:0]   pixel;
    logic [COL_W-1:0]     col;
    logic [OUT_COL_W-1:0] out_column;
    logic                 emit;
    logic                 last;
  } work_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

FILE: rtl/core/clbp_ram.sv
// ----------------------------------------------------------------------------
// clbp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data. A read and a
// write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module clbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/clbp_front.sv
// ----------------------------------------------------------------------------
// clbp_front: request intake, geometry registers and raster counters
// Accepts pixel requests, tracks column and row, decides whether the pixel
// completes an interior window and hands a work entry to the queue.
// ----------------------------------------------------------------------------
module clbp_front #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  clbp_pkg::in_item_t                  in_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [clbp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [clbp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  clbp_pkg::back_status_t              status,
  output logic                                q_valid,
  input  logic                                q_ready,
  output clbp_pkg::work_t                     q_data
);

  localparam int CW   = $clog2(MAX_COLUMNS);
  localparam int KW   = CW + 1;
  localparam int XW   = (CW > clbp_pkg::OUT_COL_W) ? CW : clbp_pkg::OUT_COL_W;
  localparam int COLW = clbp_pkg::COL_W;
  localparam int RW   = clbp_pkg::IMG_ROWS_W;

  logic [clbp_pkg::IMG_COLS_W-1:0] img_cols_r;
  logic [RW-1:0]                   img_rows_r;
  logic [CW-1:0]                   col_cnt_r, col_cnt_nxt;
  logic [RW-1:0]                   row_cnt_r, row_cnt_nxt;

  logic [KW-1:0] cols;
  logic [RW-1:0] rows;
  logic [CW-1:0] col_eff;
  logic [RW-1:0] row_eff;
  logic [KW-1:0] col_inc;
  logic [RW:0]   row_inc;
  logic [XW-1:0] col_diff;
  logic          accept;
  logic          emit;
  logic          last;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_ready && !status.clearing;
  assign q_valid   = in_valid && !status.clearing;
  assign accept    = in_valid && in_ready;

  // Geometry clamped to the supported range.
  always_comb begin
    if (img_cols_r < clbp_pkg::IMG_COLS_W'(clbp_pkg::MIN_GEOM)) begin
      cols = KW'(clbp_pkg::MIN_GEOM);
    end else if (img_cols_r > MAX_COLUMNS) begin
      cols = KW'(MAX_COLUMNS);
    end else begin
      cols = KW'(img_cols_r);
    end
    if (img_rows_r < RW'(clbp_pkg::MIN_GEOM)) begin
      rows = RW'(clbp_pkg::MIN_GEOM);
    end else begin
      rows = img_rows_r;
    end
  end

  always_comb begin
    col_eff  = in_data.frame_start ? '0 : col_cnt_r;
    row_eff  = in_data.frame_start ? '0 : row_cnt_r;
    col_inc  = KW'(col_eff) + KW'(1);
    row_inc  = {1'b0, row_eff} + (RW+1)'(1);
    emit     = (row_eff >= RW'(2)) && (KW'(col_eff) >= KW'(2));
    last     = (row_eff == rows - RW'(1)) && (KW'(col_eff) == cols - KW'(1));
    col_diff = XW'(col_eff) - XW'(2);

    if (col_inc >= cols) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_inc >= {1'b0, rows}) ? '0 : row_inc[RW-1:0];
    end else begin
      col_cnt_nxt = col_inc[CW-1:0];
      row_cnt_nxt = row_eff;
    end

    q_data.pixel      = in_data.pixel;
    q_data.col        = COLW'(col_eff);
    q_data.out_column = col_diff[clbp_pkg::OUT_COL_W-1:0];
    q_data.emit       = emit;
    q_data.last       = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_cols_r <= clbp_pkg::IMG_COLS_RESET;
      img_rows_r <= clbp_pkg::IMG_ROWS_RESET;
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          clbp_pkg::REG_IMAGE_COLUMNS: begin
            img_cols_r <= cfg_data[clbp_pkg::IMG_COLS_W-1:0];
          end
          clbp_pkg::REG_IMAGE_ROWS: begin
            img_rows_r <= cfg_data[RW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (accept) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  // A frame's final pixel always closes an interior window.
  a_last_is_emit: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last |-> emit)
    else $error("last pixel of frame without an output code");
`endif

endmodule

FILE: rtl/core/clbp_queue.sv
// ----------------------------------------------------------------------------
// clbp_queue: short work queue between the front and back parts
// A small register FIFO of work entries so that each side stalls on its own.
// ----------------------------------------------------------------------------
module clbp_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  clbp_pkg::work_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output clbp_pkg::work_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  clbp_pkg::work_t slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [NW-1:0]   cnt_r;
  logic            push;
  logic            pop;

  assign push_ready = (cnt_r != NW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

endmodule

FILE: rtl/core/clbp_back.sv
// ----------------------------------------------------------------------------
// clbp_back: line stores, window and code evaluation
// Reads and rewrites the two line stores, shifts the 3x3 window, forms the
// interpolated diagonal samples and compares all eight against the centre.
// ----------------------------------------------------------------------------
module clbp_back #(
  parameter int MAX_COLUMNS          = 1024,
  parameter int WEIGHT_FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  clbp_pkg::work_t        q_data,
  output clbp_pkg::back_status_t status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output clbp_pkg::out_item_t    out_data
);

  localparam int AW = $clog2(MAX_COLUMNS);
  localparam int F  = WEIGHT_FRACTION_BITS;
  localparam int SW = F + 10;
  localparam int PW = clbp_pkg::PIXEL_W;
  localparam int OW = clbp_pkg::OUT_COL_W;

  localparam logic [63:0] EDGE_RND =
    (clbp_pkg::EDGE_Q32 + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic [63:0] MID_RND =
    (clbp_pkg::MID_Q32 + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic [63:0] HALF_RND = 64'd1 << (F - 1);
  localparam logic [SW-1:0] EDGE_C = EDGE_RND[SW-1:0];
  localparam logic [SW-1:0] MID_C  = MID_RND[SW-1:0];
  localparam logic [SW-1:0] HALF_C = HALF_RND[SW-1:0];

  function automatic logic [SW-1:0] diag_sum(input logic [PW-1:0] corner,
                                             input logic [PW-1:0] axis_a,
                                             input logic [PW-1:0] axis_b,
                                             input logic [PW-1:0] cen);
    logic [SW-1:0] ab;
    begin
      ab = SW'(axis_a) + SW'(axis_b);
      return SW'(corner) * HALF_C + ab * EDGE_C + SW'(cen) * MID_C;
    end
  endfunction

  // Clearing sweep.
  logic          clr_r;
  logic [AW-1:0] clr_addr_r;

  // Line store port.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [2*PW-1:0] ram_wdata;
  logic          ram_re;
  logic [2*PW-1:0] ram_rdata;

  // Write forwarding for the entry written by the previous pixel.
  logic            last_wr_v_r;
  logic [AW-1:0]   last_wr_addr_r;
  logic [2*PW-1:0] last_wr_data_r;

  // Stage 1: waits for the line store read.
  logic            s1_v_r;
  clbp_pkg::work_t s1_r;
  logic [AW-1:0]   s1_addr;
  logic [2*PW-1:0] s1_rd;

  // Stage 2: window holds the neighbourhood.
  logic          s2_v_r;
  logic          s2_emit_r;
  logic          s2_last_r;
  logic [OW-1:0] s2_col_r;
  logic [PW-1:0] win_r [3][3];

  // Stage 3: samples ready for comparison.
  logic          s3_v_r;
  logic          s3_last_r;
  logic [OW-1:0] s3_col_r;
  logic [3:0]    s3_axis_r;
  logic [SW-1:0] s3_d_r [4];
  logic [PW-1:0] s3_c_r;

  // Output register.
  logic                out_v_r;
  clbp_pkg::out_item_t out_r;

  logic          out_free;
  logic          s3_free;
  logic          s2_adv;
  logic          s2_free;
  logic          s1_adv;
  logic          pop;
  logic [SW-1:0] ref_val;
  logic [PW-1:0] code;

  assign out_free = !out_v_r || out_ready;
  assign s3_free  = !s3_v_r || out_free;
  assign s2_adv   = s2_v_r && (!s2_emit_r || s3_free);
  assign s2_free  = !s2_v_r || s2_adv;
  assign s1_adv   = s1_v_r && s2_free;
  assign pop      = q_valid && !clr_r && (!s1_v_r || s1_adv);
  assign q_ready  = !clr_r && (!s1_v_r || s1_adv);

  assign status.clearing = clr_r;
  assign out_valid       = out_v_r;
  assign out_data        = out_r;

  assign s1_addr = s1_r.col[AW-1:0];
  assign s1_rd   = (last_wr_v_r && last_wr_addr_r == s1_addr) ? last_wr_data_r : ram_rdata;

  // Entry layout: upper byte is the newer row, lower byte the older row.
  always_comb begin
    if (clr_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_adv;
      ram_waddr = s1_addr;
      ram_wdata = {s1_r.pixel, s1_rd[2*PW-1:PW]};
    end
    ram_re = pop;
  end

  clbp_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_COLUMNS)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_data.col[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    ref_val = SW'(s3_c_r) << F;
    code[0] = s3_axis_r[0];
    code[1] = s3_d_r[0] > ref_val;
    code[2] = s3_axis_r[1];
    code[3] = s3_d_r[1] > ref_val;
    code[4] = s3_axis_r[2];
    code[5] = s3_d_r[2] > ref_val;
    code[6] = s3_axis_r[3];
    code[7] = s3_d_r[3] > ref_val;
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_r <= q_data;
    end
    if (s1_adv) begin
      last_wr_addr_r <= s1_addr;
      last_wr_data_r <= {s1_r.pixel, s1_rd[2*PW-1:PW]};
      s2_emit_r      <= s1_r.emit;
      s2_last_r      <= s1_r.last;
      s2_col_r       <= s1_r.out_column;
    end
    if (s2_adv && s2_emit_r) begin
      s3_last_r    <= s2_last_r;
      s3_col_r     <= s2_col_r;
      s3_c_r       <= win_r[1][1];
      s3_axis_r[0] <= win_r[1][2] > win_r[1][1];
      s3_axis_r[1] <= win_r[0][1] > win_r[1][1];
      s3_axis_r[2] <= win_r[1][0] > win_r[1][1];
      s3_axis_r[3] <= win_r[2][1] > win_r[1][1];
      s3_d_r[0]    <= diag_sum(win_r[0][2], win_r[0][1], win_r[1][2], win_r[1][1]);
      s3_d_r[1]    <= diag_sum(win_r[0][0], win_r[0][1], win_r[1][0], win_r[1][1]);
      s3_d_r[2]    <= diag_sum(win_r[2][0], win_r[2][1], win_r[1][0], win_r[1][1]);
      s3_d_r[3]    <= diag_sum(win_r[2][2], win_r[2][1], win_r[1][2], win_r[1][1]);
    end
    if (s3_v_r && out_free) begin
      out_r.lbp_code      <= code;
      out_r.out_column    <= s3_col_r;
      out_r.last_of_frame <= s3_last_r;
    end
  end

  // Control state and window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      last_wr_v_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_COLUMNS - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (pop) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        last_wr_v_r <= 1'b1;
        s2_v_r      <= 1'b1;
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= s1_rd[PW-1:0];
        win_r[1][2] <= s1_rd[2*PW-1:PW];
        win_r[2][2] <= s1_r.pixel;
      end else if (s2_adv) begin
        s2_v_r <= 1'b0;
      end
      if (s2_adv && s2_emit_r) begin
        s3_v_r <= 1'b1;
      end else if (s3_v_r && out_free) begin
        s3_v_r <= 1'b0;
      end
      if (s3_v_r && out_free) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // A waiting stage 1 must see its read data held: no stray line store read.
  a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> $stable(ram_rdata))
    else $error("line store read data changed under a waiting pixel");

  // The pipeline is empty for the whole clearing sweep.
  a_empty_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !s1_v_r && !s2_v_r && !s3_v_r && !out_v_r)
    else $error("pixel in flight during line store clearing");

  // Pixel writes never collide with the clearing sweep.
  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |-> !clr_r)
    else $error("pixel write during line store clearing");
`endif

endmodule

FILE: rtl/core/circular_lbp_8_1.sv
// ----------------------------------------------------------------------------
// circular_lbp_8_1: streaming circular local binary pattern, radius 1
// Raster pixel stream in, one 8-bit LBP code per interior pixel out.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock unless back-pressure or the
// line store sweep holds it and, in steady state, returns one code request
// per clock for every interior pixel (border pixels produce nothing). The
// rate is set by the single read and single write per cycle of the line store
// RAM, which holds both previous rows side by side in one word so each pixel
// costs exactly one read and one write. An accepted pixel passes through the
// queue, line store read, window shift, diagonal sums and compare into the
// output register. After reset the line store is swept to zero, one column
// per cycle, across all MAX_COLUMNS columns; in_ready stays low during the
// sweep while configuration writes are still taken. Geometry registers are
// image_columns (index 0) and image_rows (index 1) and should be written only
// while no request is in flight.
// ----------------------------------------------------------------------------
module circular_lbp_8_1 #(
  parameter int MAX_COLUMNS          = 1024,
  parameter int WEIGHT_FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Pixel requests in raster order.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  clbp_pkg::in_item_t               in_data,
  // Code requests.
  output logic                             out_valid,
  input  logic                             out_ready,
  output clbp_pkg::out_item_t              out_data,
  // Register write requests.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [clbp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [clbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Front side: classified work entries toward the queue.
  logic            fq_valid;
  logic            fq_ready;
  clbp_pkg::work_t fq_data;

  // Back side: entries leaving the queue.
  logic            qb_valid;
  logic            qb_ready;
  clbp_pkg::work_t qb_data;

  clbp_pkg::back_status_t back_status;

  // The front counts columns and rows and decides, before any pixel data is
  // touched, whether a pixel finishes an interior window and whether it is
  // the last of its frame.
  clbp_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (back_status),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_data    (fq_data)
  );

  // Two entries are enough to keep a pixel per clock flowing while the back
  // part and the front part stall independently.
  clbp_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // The back part owns the line store, the 3x3 window and the arithmetic.
  // Diagonal samples are bilinear blends with weights rounded to
  // WEIGHT_FRACTION_BITS fractional bits; a bit is set when its sample is
  // strictly above the scaled centre.
  clbp_back #(
    .MAX_COLUMNS          (MAX_COLUMNS),
    .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_data    (qb_data),
    .status    (back_status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: bench/clbp_code_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clbp_code_checker: code predictor and comparator for circular_lbp_8_1
// Watches the pixel, code and register channels, keeps its own copy of the
// line stores, window, counters and geometry, works out the LBP code due for
// each accepted pixel and compares every delivered code against it in order.
// ----------------------------------------------------------------------------
module clbp_code_checker #(
  parameter int MAX_COLUMNS          = 1024,
  parameter int WEIGHT_FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  clbp_pkg::in_item_t               in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  clbp_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [clbp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [clbp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               pending_codes
);

  localparam int WFB = WEIGHT_FRACTION_BITS;
  localparam logic [39:0] HALF_W = 40'd1 << (WFB - 1);
  localparam logic [39:0] EDGE_W =
    40'((clbp_pkg::EDGE_Q32 + (64'd1 << (31 - WFB))) >> (32 - WFB));
  localparam logic [39:0] MID_W  =
    40'((clbp_pkg::MID_Q32 + (64'd1 << (31 - WFB))) >> (32 - WFB));

  logic [clbp_pkg::IMG_COLS_W-1:0] columns_reg;
  logic [clbp_pkg::IMG_ROWS_W-1:0] rows_reg;
  logic [clbp_pkg::PIXEL_W-1:0]    two_up_line [MAX_COLUMNS];
  logic [clbp_pkg::PIXEL_W-1:0]    one_up_line [MAX_COLUMNS];
  logic [clbp_pkg::PIXEL_W-1:0]    win [3][3];
  int                              col_count;
  int                              row_count;
  clbp_pkg::out_item_t             expected_codes [$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: code mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Bilinear sample at a diagonal, in Q8.F.
  function automatic logic [39:0] diagonal_sample(input logic [7:0] corner, side_a, side_b,
                                                  centre);
    return HALF_W * corner + EDGE_W * (side_a + side_b) + MID_W * centre;
  endfunction

  task automatic take_pixel(input clbp_pkg::in_item_t req);
    int                  width;
    int                  height;
    int                  col;
    int                  row;
    int                  k;
    logic [7:0]          c, e, n, w, s;
    logic [39:0]         centre_ref;
    logic [39:0]         sample [8];
    clbp_pkg::out_item_t code;
    width = columns_reg;
    if (width < clbp_pkg::MIN_GEOM) width = clbp_pkg::MIN_GEOM;
    else if (width > MAX_COLUMNS) width = MAX_COLUMNS;
    height = rows_reg;
    if (height < clbp_pkg::MIN_GEOM) height = clbp_pkg::MIN_GEOM;
    else if (height > clbp_pkg::MAX_ROWS) height = clbp_pkg::MAX_ROWS;

    if (req.frame_start) begin
      col_count = 0;
      row_count = 0;
    end
    col = (col_count >= MAX_COLUMNS) ? MAX_COLUMNS - 1 : col_count;
    row = row_count;

    for (k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = two_up_line[col];
    win[1][2] = one_up_line[col];
    win[2][2] = req.pixel;
    two_up_line[col] = one_up_line[col];
    one_up_line[col] = req.pixel;

    if (row >= 2 && col >= 2) begin
      c = win[1][1];
      e = win[1][2];
      n = win[0][1];
      w = win[1][0];
      s = win[2][1];
      centre_ref = 40'(c) << WFB;
      sample[0] = 40'(e) << WFB;
      sample[1] = diagonal_sample(win[0][2], n, e, c);
      sample[2] = 40'(n) << WFB;
      sample[3] = diagonal_sample(win[0][0], n, w, c);
      sample[4] = 40'(w) << WFB;
      sample[5] = diagonal_sample(win[2][0], s, w, c);
      sample[6] = 40'(s) << WFB;
      sample[7] = diagonal_sample(win[2][2], s, e, c);
      for (k = 0; k < 8; k++) code.lbp_code[k] = (sample[k] > centre_ref);
      code.out_column    = clbp_pkg::OUT_COL_W'(col - 2);
      code.last_of_frame = (row == height - 1) && (col == width - 1);
      expected_codes = {expected_codes, code};
    end

    if (col_count + 1 >= width) begin
      col_count = 0;
      row_count = (row_count + 1 >= height) ? 0 : row_count + 1;
    end else begin
      col_count = col_count + 1;
    end
  endtask

  task automatic compare_code(input clbp_pkg::out_item_t got);
    clbp_pkg::out_item_t want;
    if (expected_codes.size() == 0) begin
      report_mismatch($sformatf("code %02h at column %0d with none expected",
                                got.lbp_code, got.out_column));
      return;
    end
    want = expected_codes.pop_front();
    if (got.lbp_code !== want.lbp_code)
      report_mismatch($sformatf("lbp_code %02h, expected %02h (column %0d)",
                                got.lbp_code, want.lbp_code, want.out_column));
    if (got.out_column !== want.out_column)
      report_mismatch($sformatf("out_column %0d, expected %0d",
                                got.out_column, want.out_column));
    if (got.last_of_frame !== want.last_of_frame)
      report_mismatch($sformatf("last_of_frame %0b, expected %0b (column %0d)",
                                got.last_of_frame, want.last_of_frame, want.out_column));
  endtask

  always @(posedge clk) begin : watch
    int i;
    if (!rst_n) begin
      fail_count  = 0;
      columns_reg = clbp_pkg::IMG_COLS_RESET;
      rows_reg    = clbp_pkg::IMG_ROWS_RESET;
      for (i = 0; i < MAX_COLUMNS; i++) begin
        two_up_line[i] = '0;
        one_up_line[i] = '0;
      end
      for (i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
      col_count = 0;
      row_count = 0;
      expected_codes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == clbp_pkg::REG_IMAGE_COLUMNS)
          columns_reg = cfg_data[clbp_pkg::IMG_COLS_W-1:0];
        else if (cfg_index == clbp_pkg::REG_IMAGE_ROWS)
          rows_reg = cfg_data[clbp_pkg::IMG_ROWS_W-1:0];
      end
      if (out_valid && out_ready) compare_code(out_data);
      if (in_valid && in_ready) take_pixel(in_data);
    end
    pending_codes <= expected_codes.size();
  end

endmodule

FILE: bench/circular_lbp_8_1_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_lbp_8_1_tb: stimulus and verdict for the circular LBP block
// Drives pixel and register requests, paces the code channel and leaves all
// prediction and comparison to clbp_code_checker beside the block.
// ----------------------------------------------------------------------------
module circular_lbp_8_1_tb;

  localparam int MAX_COLUMNS      = 1024;
  // Settling margin beyond the depth of the block's pipeline.
  localparam int SETTLE_CYCLES    = 16;
  // Cap on the whole run, counting the line store sweep after reset; it
  // leaves ample margin over the slowest correct run.
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PIXELS    = 200;
  localparam int WIDE_RUN         = 600;
  localparam int FRAME_CAP        = 160;
  localparam int LONG_HOLD        = 300;
  localparam int HOLD_AFTER_CODES = 200;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  clbp_pkg::in_item_t               in_data;
  logic                             out_valid;
  logic                             out_ready;
  clbp_pkg::out_item_t              out_data;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [clbp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [clbp_pkg::CFG_DATA_W-1:0]  cfg_data;

  int fail_count;
  int pending_codes;
  int cycle_count  = 0;
  int codes_taken  = 0;
  int pixels_sent  = 0;
  // Percentage chance of a sender gap before each pixel request.
  int idle_pct     = 0;
  // Set for the closing stretch of the run, where neither side idles.
  bit quiet_tail   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  circular_lbp_8_1 #(
    .MAX_COLUMNS          (MAX_COLUMNS),
    .WEIGHT_FRACTION_BITS (16)
  ) dut (.*);

  clbp_code_checker #(
    .MAX_COLUMNS          (MAX_COLUMNS),
    .WEIGHT_FRACTION_BITS (16)
  ) checker_i (.*);

  // Watchdog. The block drops nothing and never stalls forever, so running
  // into this limit means a hang or lost codes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (out_valid && out_ready) codes_taken <= codes_taken + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // All inputs change only through nonblocking assignments right after a
  // rising edge, and every handshake is judged on values read right after
  // the edge, before any of those updates land, so both sides see the same
  // pre-edge state.

  // One pixel request, optionally preceded by a random gap. Valid stays high
  // on return so back-to-back requests do not drop it in between.
  task automatic send_pixel(input logic [clbp_pkg::PIXEL_W-1:0] px, input bit fs);
    int gap;
    if (!quiet_tail && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pixel: px, frame_start: fs};
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  // Both geometry registers, back to back. Only called while the block is
  // idle.
  task automatic write_geometry(input logic [clbp_pkg::CFG_DATA_W-1:0] cols_v, rows_v);
    cfg_valid <= 1'b1;
    cfg_index <= clbp_pkg::REG_IMAGE_COLUMNS;
    cfg_data  <= cols_v;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= clbp_pkg::REG_IMAGE_ROWS;
    cfg_data  <= rows_v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every predicted code has come back, then give the pipeline
  // time to finish pixels that produce no code at all.
  task automatic settle();
    @(posedge clk);
    while (pending_codes != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel values lean toward a per-run base level so that neighbours often
  // tie with the centre or miss it by one grey level, which is where the
  // strict comparison and the rounded diagonal weights matter.
  function automatic logic [clbp_pkg::PIXEL_W-1:0] pick_pixel(
      input logic [clbp_pkg::PIXEL_W-1:0] base);
    case ($urandom_range(0, 7))
      0, 1, 2: return clbp_pkg::PIXEL_W'($urandom);
      3, 4:    return base;
      5:       return base + 8'd1;
      6:       return base - 8'd1;
      default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  // A run of pixels. The first one may mark a new frame; with noise on, a
  // rare frame_start lands in the middle and restarts the counters.
  task automatic send_run(input int count, input bit mark_start, input bit noisy);
    int                           k;
    bit                           fs;
    logic [clbp_pkg::PIXEL_W-1:0] base;
    base = clbp_pkg::PIXEL_W'($urandom_range(0, 255));
    for (k = 0; k < count; k++) begin
      fs = (k == 0) ? mark_start : (noisy && $urandom_range(0, 79) == 0);
      send_pixel(pick_pixel(base), fs);
    end
  endtask

  // Code receiver. It alternates calm stretches with stretches of random
  // back-pressure bursts. Once, in the middle of the wide frame, it holds
  // off for a long time while the sender keeps offering pixels, so the
  // block's internal queue fills and in_ready drops.
  initial begin : receiver
    int  stretch;
    bit  calm;
    bit  held;
    out_ready <= 1'b0;
    held = 1'b0;
    @(posedge clk);
    forever begin
      calm    = ($urandom_range(0, 2) == 0);
      stretch = $urandom_range(20, 200);
      repeat (stretch) begin
        if (!held && !quiet_tail && codes_taken >= HOLD_AFTER_CODES) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end else if (!quiet_tail && !calm && $urandom_range(0, 4) == 0) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk);
        end else begin
          out_ready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int cols_w;
    int rows_w;
    int width;
    int height;
    int frames;
    int f;
    int k;
    int len;
    int first_random;
    bit carry_on;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= clbp_pkg::REG_IMAGE_COLUMNS;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Both registers are written below their legal range, so
    // the block must clamp to a 3x3 frame: one code per frame, flagged as
    // last. The first pixel request waits out the line store sweep.
    write_geometry(0, 2);
    // Bright centre on black: no neighbour exceeds it.
    for (k = 0; k < 9; k++) send_pixel((k == 4) ? 8'hFF : 8'h00, k == 0);
    // Black centre on white: every neighbour exceeds it.
    for (k = 0; k < 9; k++) send_pixel((k == 4) ? 8'h00 : 8'hFF, k == 0);
    // A frame cut short by a new frame_start, then a flat frame. On a flat
    // patch the diagonal weights sum to exactly one, so every sample ties
    // with the centre and no bit may be set.
    for (k = 0; k < 3; k++) send_pixel(8'd77, k == 0);
    for (k = 0; k < 9; k++) send_pixel(8'd128, k == 0);
    in_valid <= 1'b0;
    settle();

    // Widest image. Start a 3x3 frame and stop at the first pixel of its
    // last row, then widen to the clamped maximum without a new frame_start:
    // the counters carry on, and the first part of that row yields codes
    // whose out_column runs well into the upper half of its range.
    write_geometry(3, 3);
    send_run(7, 1'b1, 1'b0);
    in_valid <= 1'b0;
    settle();
    write_geometry(2047, 3);
    send_run(WIDE_RUN, 1'b0, 1'b0);
    in_valid <= 1'b0;
    settle();

    // Random part: phases of frames of at most FRAME_CAP pixels with random
    // content under random small geometries, now and then an out-of-range or
    // tallest setting. A phase may stop mid-frame; the next may continue it
    // under its new geometry, so counters at or past the new limit must wrap.
    first_random = pixels_sent;
    carry_on = 1'b0;
    while (pixels_sent - first_random < RANDOM_PIXELS) begin
      cols_w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      case ($urandom_range(0, 9))
        0:       rows_w = $urandom_range(0, 2);
        1:       rows_w = clbp_pkg::MAX_ROWS;
        default: rows_w = $urandom_range(3, 8);
      endcase
      write_geometry(clbp_pkg::CFG_DATA_W'(cols_w), clbp_pkg::CFG_DATA_W'(rows_w));
      width  = (cols_w < clbp_pkg::MIN_GEOM) ? clbp_pkg::MIN_GEOM : cols_w;
      height = (rows_w < clbp_pkg::MIN_GEOM) ? clbp_pkg::MIN_GEOM : rows_w;
      len    = (width * height > FRAME_CAP) ? FRAME_CAP : width * height;
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 35;
      endcase
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) send_run(len, !(f == 0 && carry_on), 1'b1);
      carry_on = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        send_run($urandom_range(1, len - 1), 1'b1, 1'b1);
        carry_on = $urandom_range(0, 1);
      end
      in_valid <= 1'b0;
      settle();
    end

    // Closing stretch: one more frame with neither side idling.
    quiet_tail = 1'b1;
    write_geometry(8, 6);
    send_run(48, 1'b1, 1'b0);
    in_valid <= 1'b0;
    settle();

    if (fail_count == 0 && pending_codes == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
